### rtl/rhc_pkg.sv
package rhc_pkg;

  localparam int CHANNEL_BITS_DEF = 8;

  // Hue is kept in 1/64 degree.
  localparam int HUE_W      = 15;
  localparam int HUE_Q_W    = 12;
  localparam int HUE_SIXTH  = 3840;
  localparam int HUE_FULL   = 23040;
  localparam int HUE_BASE_G = 2 * HUE_SIXTH;
  localparam int HUE_BASE_B = 4 * HUE_SIXTH;

  typedef enum logic [1:0] {
    SEC_RED   = 2'd0,
    SEC_GREEN = 2'd1,
    SEC_BLUE  = 2'd2
  } sector_e;

endpackage

### rtl/rhc_if.sv
interface rhc_rgb_if
  import rhc_pkg::*;
#(
  parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
);
  logic                    valid;
  logic                    ready;
  logic [CHANNEL_BITS-1:0] red;
  logic [CHANNEL_BITS-1:0] green;
  logic [CHANNEL_BITS-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rhc_hsv_if
  import rhc_pkg::*;
#(
  parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
);
  logic                    valid;
  logic                    ready;
  logic [HUE_W-1:0]        hue;
  logic [CHANNEL_BITS-1:0] saturation;
  logic [CHANNEL_BITS-1:0] brightness;

  modport source (output valid, output hue, output saturation, output brightness,
                  input ready);
  modport sink   (input valid, input hue, input saturation, input brightness,
                  output ready);
endinterface

### rtl/rgb_to_hsv_converter_top.sv
// RGB to HSV pixel converter. Takes one pixel per clock on pix_i, unless hsv_o back-pressure
// stalls it, and returns hue (1/64 degree, 0..23039), saturation (full scale means fully
// saturated) and brightness (largest channel) on hsv_o, in order. The two restoring dividers
// resolve one quotient bit per pipeline stage; the throughput is one pixel per clock while
// hsv_o is ready. Every stage has its own valid bit and holds only while the stage after it
// is full and stalled, so bubbles close up under back-pressure. Grey pixels give hue 0 and
// saturation 0.
module rgb_to_hsv_converter_top
  import rhc_pkg::*;
#(
  parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rhc_rgb_if.sink   pix_i,
  rhc_hsv_if.source hsv_o
);

  localparam int CB    = CHANNEL_BITS;
  localparam int QB    = (CB > HUE_Q_W) ? CB : HUE_Q_W;
  localparam int NUM_W = QB + CB;
  localparam logic [NUM_W-1:0] FULL_N  = NUM_W'((1 << CB) - 1);
  localparam logic [NUM_W-1:0] SIXTH_N = NUM_W'(HUE_SIXTH);

  // ---------------- stage 1: extremes, sector, difference ----------------
  logic          v1_q;
  logic [CB-1:0] hi1_d, hi1_q, dlt1_d, dlt1_q, mag1_d, mag1_q;
  logic          neg1_d, neg1_q;
  sector_e       sec1_d, sec1_q;
  logic          en1, en2, en_out;

  always_comb begin
    logic [CB-1:0] lo, plus, minus;
    hi1_d = pix_i.red;
    lo    = pix_i.red;
    if (pix_i.green > hi1_d) hi1_d = pix_i.green;
    if (pix_i.blue > hi1_d)  hi1_d = pix_i.blue;
    if (pix_i.green < lo)    lo = pix_i.green;
    if (pix_i.blue < lo)     lo = pix_i.blue;
    dlt1_d = hi1_d - lo;
    priority if (hi1_d == pix_i.red) begin
      sec1_d = SEC_RED;
      plus   = pix_i.green;
      minus  = pix_i.blue;
    end else if (hi1_d == pix_i.green) begin
      sec1_d = SEC_GREEN;
      plus   = pix_i.blue;
      minus  = pix_i.red;
    end else begin
      sec1_d = SEC_BLUE;
      plus   = pix_i.red;
      minus  = pix_i.green;
    end
    neg1_d = plus < minus;
    mag1_d = neg1_d ? (minus - plus) : (plus - minus);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en1) begin
      v1_q <= pix_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      hi1_q  <= hi1_d;
      dlt1_q <= dlt1_d;
      mag1_q <= mag1_d;
      neg1_q <= neg1_d;
      sec1_q <= sec1_d;
    end
  end

  // ---------------- stage 2: numerators ----------------
  logic             v2_q;
  logic [CB-1:0]    hi2_q, dlt2_q;
  logic [NUM_W-1:0] hnum2_q, snum2_q;
  logic             neg2_q, zero2_q;
  sector_e          sec2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      hi2_q   <= hi1_q;
      dlt2_q  <= dlt1_q;
      hnum2_q <= NUM_W'(mag1_q) * SIXTH_N;
      snum2_q <= NUM_W'(dlt1_q) * FULL_N;
      neg2_q  <= neg1_q;
      zero2_q <= (dlt1_q == '0);
      sec2_q  <= sec1_q;
    end
  end

  // ---------------- division stages: one quotient bit each ----------------
  logic             dv_q   [QB];
  logic [CB-1:0]    hden_q [QB];
  logic [CB-1:0]    sden_q [QB];
  logic [NUM_W-1:0] hnum_q [QB];
  logic [NUM_W-1:0] snum_q [QB];
  logic [QB-1:0]    hq_q   [QB];
  logic [QB-1:0]    sq_q   [QB];
  logic             dneg_q [QB];
  logic             dzero_q[QB];
  sector_e          dsec_q [QB];
  logic             en_div [QB];

  for (genvar k = 0; k < QB; k++) begin : g_div
    localparam int SH = QB - 1 - k;
    logic             v_in, neg_in, zero_in;
    logic [CB-1:0]    hden_in, sden_in;
    logic [NUM_W-1:0] hnum_in, snum_in, hsub, ssub;
    logic [QB-1:0]    hq_in, sq_in;
    sector_e          sec_in;
    logic             hge, sge;

    if (k == 0) begin : g_first
      assign v_in    = v2_q;
      assign hden_in = dlt2_q;
      assign sden_in = hi2_q;
      assign hnum_in = hnum2_q;
      assign snum_in = snum2_q;
      assign hq_in   = '0;
      assign sq_in   = '0;
      assign neg_in  = neg2_q;
      assign zero_in = zero2_q;
      assign sec_in  = sec2_q;
    end else begin : g_next
      assign v_in    = dv_q[k-1];
      assign hden_in = hden_q[k-1];
      assign sden_in = sden_q[k-1];
      assign hnum_in = hnum_q[k-1];
      assign snum_in = snum_q[k-1];
      assign hq_in   = hq_q[k-1];
      assign sq_in   = sq_q[k-1];
      assign neg_in  = dneg_q[k-1];
      assign zero_in = dzero_q[k-1];
      assign sec_in  = dsec_q[k-1];
    end

    if (k == QB - 1) begin : g_last_en
      assign en_div[k] = !dv_q[k] || en_out;
    end else begin : g_mid_en
      assign en_div[k] = !dv_q[k] || en_div[k+1];
    end

    assign hsub = NUM_W'(hden_in) << SH;
    assign ssub = NUM_W'(sden_in) << SH;
    assign hge  = hnum_in >= hsub;
    assign sge  = snum_in >= ssub;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[k] <= 1'b0;
      end else if (en_div[k]) begin
        dv_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_div[k]) begin
        hden_q[k]  <= hden_in;
        sden_q[k]  <= sden_in;
        hnum_q[k]  <= hge ? (hnum_in - hsub) : hnum_in;
        snum_q[k]  <= sge ? (snum_in - ssub) : snum_in;
        hq_q[k]    <= {hq_in[QB-2:0], hge};
        sq_q[k]    <= {sq_in[QB-2:0], sge};
        dneg_q[k]  <= neg_in;
        dzero_q[k] <= zero_in;
        dsec_q[k]  <= sec_in;
      end
    end
  end

  assign en2     = !v2_q || en_div[0];
  assign en1     = !v1_q || en2;
  assign pix_i.ready = en1;

  // ---------------- output stage: sector offset and wrap ----------------
  logic             out_v_q;
  logic [HUE_W-1:0] hue_d, hue_q;
  logic [CB-1:0]    sat_q, bri_q;

  assign en_out = !out_v_q || hsv_o.ready;

  always_comb begin
    logic [HUE_W-1:0] base, q;
    unique case (dsec_q[QB-1])
      SEC_RED:   base = '0;
      SEC_GREEN: base = HUE_W'(HUE_BASE_G);
      SEC_BLUE:  base = HUE_W'(HUE_BASE_B);
      default:   base = '0;
    endcase
    q = HUE_W'(hq_q[QB-1][HUE_Q_W-1:0]);
    if (dzero_q[QB-1]) begin
      hue_d = '0;
    end else if (!dneg_q[QB-1]) begin
      hue_d = base + q;
    end else if (base >= q) begin
      hue_d = base - q;
    end else begin
      hue_d = base + HUE_W'(HUE_FULL) - q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en_out) begin
      out_v_q <= dv_q[QB-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_out) begin
      hue_q <= hue_d;
      sat_q <= dzero_q[QB-1] ? '0 : sq_q[QB-1][CB-1:0];
      bri_q <= sden_q[QB-1];
    end
  end

  assign hsv_o.valid      = out_v_q;
  assign hsv_o.hue        = hue_q;
  assign hsv_o.saturation = sat_q;
  assign hsv_o.brightness = bri_q;

`ifndef SYNTHESIS
  a_hue_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    hsv_o.valid |-> hsv_o.hue < HUE_W'(HUE_FULL))
    else $error("hue out of range");

  a_sat_needs_bri : assert property (@(posedge clk_i) disable iff (!rst_ni)
    hsv_o.valid && hsv_o.saturation != '0 |-> hsv_o.brightness != '0)
    else $error("saturation without brightness");

  a_grey_hue : assert property (@(posedge clk_i) disable iff (!rst_ni)
    hsv_o.valid && hsv_o.saturation == '0 |-> hsv_o.hue == '0)
    else $error("grey pixel with nonzero hue");

  a_stall_origin : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pix_i.ready |-> hsv_o.valid && !hsv_o.ready)
    else $error("input stalled without output back-pressure");
`endif

endmodule

### test/rgb_to_hsv_converter_top_tb.sv
`timescale 1ns / 1ps

module rgb_to_hsv_converter_top_tb;
  import rhc_pkg::*;

  localparam int CB           = CHANNEL_BITS_DEF;
  localparam int CHAN_MAX     = (1 << CB) - 1;
  localparam int PIXEL_COUNT  = 650;
  localparam int IDLE_LIMIT   = 4000;
  localparam int SETTLE_WAIT  = 40;

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [CB-1:0]    saturation;
    logic [CB-1:0]    brightness;
  } hsv_t;

  logic clk;
  logic rst_n;

  rhc_rgb_if #(.CHANNEL_BITS(CB)) pix_if ();
  rhc_hsv_if #(.CHANNEL_BITS(CB)) hsv_if ();

  rgb_to_hsv_converter_top #(
    .CHANNEL_BITS(CB)
  ) u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .pix_i  (pix_if),
    .hsv_o  (hsv_if)
  );

  hsv_t expected_hsv_q[$];
  int   mismatch_count = 0;
  int   idle_cycles    = 0;
  bit   tx_steady      = 1'b0;
  bit   rx_steady      = 1'b0;

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // Fixed-point HSV of one pixel; hue in 1/64 degree.
  function automatic hsv_t compute_hsv(logic [CB-1:0] r, logic [CB-1:0] g, logic [CB-1:0] b);
    hsv_t    res;
    int      ri;
    int      gi;
    int      bi;
    int      hi;
    int      lo;
    int      delta;
    int      base;
    int      plus;
    int      minus;
    int      mag;
    int      h;
    sector_e sec;
    ri = int'(r);
    gi = int'(g);
    bi = int'(b);
    hi = ri;
    lo = ri;
    if (gi > hi) hi = gi;
    if (bi > hi) hi = bi;
    if (gi < lo) lo = gi;
    if (bi < lo) lo = bi;
    delta = hi - lo;
    res.brightness = hi[CB-1:0];
    res.hue        = '0;
    res.saturation = '0;
    if (delta != 0) begin
      // ties go red, then green, then blue
      if (hi == ri) sec = SEC_RED;
      else if (hi == gi) sec = SEC_GREEN;
      else sec = SEC_BLUE;
      case (sec)
        SEC_RED: begin
          base = 0;
          plus = gi;
          minus = bi;
        end
        SEC_GREEN: begin
          base = HUE_BASE_G;
          plus = bi;
          minus = ri;
        end
        default: begin
          base = HUE_BASE_B;
          plus = ri;
          minus = gi;
        end
      endcase
      if (plus >= minus) begin
        mag = (HUE_SIXTH * (plus - minus)) / delta;
        h = base + mag;
      end else begin
        mag = (HUE_SIXTH * (minus - plus)) / delta;
        h = base - mag;
      end
      if (h < 0) h += HUE_FULL;
      res.hue        = h[HUE_W-1:0];
      res.saturation = CB'((CHAN_MAX * delta) / hi);
    end
    return res;
  endfunction

  function automatic int draw_wait(bit steady);
    int w;
    if (steady) return 0;
    w = $urandom_range(0, 3);
    // one draw in four gives a back-to-back beat; the rest reach the full range
    if (w == 0) return 0;
    return $urandom_range(0, 16);
  endfunction

  // Send one pixel; returns at the edge where the beat is taken.
  task automatic send_pixel(logic [CB-1:0] r, logic [CB-1:0] g, logic [CB-1:0] b);
    int gap;
    gap = draw_wait(tx_steady);
    if (gap > 0) begin
      pix_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_if.valid <= 1'b1;
    pix_if.red   <= r;
    pix_if.green <= g;
    pix_if.blue  <= b;
    do @(posedge clk); while (pix_if.ready !== 1'b1);
  endtask

  // Hold off the sender until the pipeline has returned every result.
  task automatic drain_pipeline();
    pix_if.valid <= 1'b0;
    do @(posedge clk); while (expected_hsv_q.size() != 0);
  endtask

  task automatic test_grey();
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd1, 8'd1, 8'd1);
    send_pixel(8'd128, 8'd128, 8'd128);
  endtask

  task automatic test_primaries();
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd255);
    send_pixel(8'd1, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd254, 8'd254);
  endtask

  task automatic test_sector_ties();
    send_pixel(8'd200, 8'd200, 8'd50);
    send_pixel(8'd50, 8'd200, 8'd200);
    send_pixel(8'd200, 8'd50, 8'd200);
    // red on top with blue over green: hue wraps below zero
    send_pixel(8'd255, 8'd0, 8'd1);
    send_pixel(8'd255, 8'd1, 8'd0);
    send_pixel(8'd0, 8'd1, 8'd255);
    send_pixel(8'd1, 8'd0, 8'd255);
    send_pixel(8'd1, 8'd0, 8'd1);
    send_pixel(8'd0, 8'd1, 8'd0);
  endtask

  function automatic logic [CB-1:0] pick_edge_value();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return CB'(1);
      2: return CB'(CHAN_MAX - 1);
      3: return CB'(CHAN_MAX);
      4: return CB'(CHAN_MAX / 2);
      default: return CB'(CHAN_MAX / 2 + 1);
    endcase
  endfunction

  task automatic test_random_pixels();
    logic [CB-1:0] r;
    logic [CB-1:0] g;
    logic [CB-1:0] b;
    int hi;
    int lo;
    int v;
    for (int i = 0; i < PIXEL_COUNT; i++) begin
      if (i % 80 == 0) begin
        tx_steady = ($urandom_range(0, 3) == 0);
        rx_steady = ($urandom_range(0, 3) == 0);
      end
      if (i == PIXEL_COUNT / 2) drain_pipeline();
      case ($urandom_range(0, 9))
        5: begin
          v = $urandom_range(0, CHAN_MAX - 3);
          r = CB'(v + $urandom_range(0, 3));
          g = CB'(v + $urandom_range(0, 3));
          b = CB'(v + $urandom_range(0, 3));
        end
        6: begin
          hi = $urandom_range(1, CHAN_MAX);
          lo = $urandom_range(0, hi - 1);
          r = CB'(hi);
          g = CB'(hi);
          b = CB'(hi);
          case ($urandom_range(0, 2))
            0: r = CB'(lo);
            1: g = CB'(lo);
            default: b = CB'(lo);
          endcase
          // one random channel anywhere in 0..hi
          if ($urandom_range(0, 1) == 1) begin
            case ($urandom_range(0, 2))
              0: r = CB'($urandom_range(0, hi));
              1: g = CB'($urandom_range(0, hi));
              default: b = CB'($urandom_range(0, hi));
            endcase
          end
        end
        7: begin
          r = CB'($urandom_range(0, CHAN_MAX));
          g = r;
          b = r;
        end
        8: begin
          r = pick_edge_value();
          g = pick_edge_value();
          b = pick_edge_value();
        end
        9: begin
          r = CB'($urandom_range(0, CHAN_MAX));
          g = CB'($urandom_range(0, CHAN_MAX));
          b = CB'($urandom_range(0, CHAN_MAX));
          case ($urandom_range(0, 2))
            0: r = CB'(CHAN_MAX);
            1: g = CB'(CHAN_MAX);
            default: b = CB'(CHAN_MAX);
          endcase
        end
        default: begin
          r = CB'($urandom_range(0, CHAN_MAX));
          g = CB'($urandom_range(0, CHAN_MAX));
          b = CB'($urandom_range(0, CHAN_MAX));
        end
      endcase
      send_pixel(r, g, b);
    end
  endtask

  // Record the expected result of every pixel beat.
  always @(posedge clk) begin
    if (rst_n && pix_if.valid === 1'b1 && pix_if.ready === 1'b1) begin
      expected_hsv_q.push_back(compute_hsv(pix_if.red, pix_if.green, pix_if.blue));
    end
  end

  always @(posedge clk) begin
    hsv_t want;
    if (rst_n && hsv_if.valid === 1'b1 && hsv_if.ready === 1'b1) begin
      if (expected_hsv_q.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result expected none actual hue %0d sat %0d val %0d",
                 $time, hsv_if.hue, hsv_if.saturation, hsv_if.brightness);
      end else begin
        want = expected_hsv_q.pop_front();
        if (hsv_if.hue !== want.hue) begin
          mismatch_count++;
          $display("%0t: hue expected %0d actual %0d", $time, want.hue, hsv_if.hue);
        end
        if (hsv_if.saturation !== want.saturation) begin
          mismatch_count++;
          $display("%0t: saturation expected %0d actual %0d", $time, want.saturation,
                   hsv_if.saturation);
        end
        if (hsv_if.brightness !== want.brightness) begin
          mismatch_count++;
          $display("%0t: brightness expected %0d actual %0d", $time, want.brightness,
                   hsv_if.brightness);
        end
      end
    end
  end

  // Result side back-pressure.
  initial begin
    int stall;
    hsv_if.ready <= 1'b0;
    @(posedge rst_n);
    @(posedge clk);
    forever begin
      stall = draw_wait(rx_steady);
      if (stall > 0) begin
        hsv_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      hsv_if.ready <= 1'b1;
      do @(posedge clk); while (hsv_if.valid !== 1'b1);
    end
  end

  always @(posedge clk) begin
    if ((pix_if.valid === 1'b1 && pix_if.ready === 1'b1) ||
        (hsv_if.valid === 1'b1 && hsv_if.ready === 1'b1)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, expected_hsv_q.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    rst_n        <= 1'b0;
    pix_if.valid <= 1'b0;
    pix_if.red   <= '0;
    pix_if.green <= '0;
    pix_if.blue  <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_grey();
    test_primaries();
    test_sector_ties();
    test_random_pixels();

    pix_if.valid <= 1'b0;
    do @(posedge clk); while (expected_hsv_q.size() != 0);
    repeat (SETTLE_WAIT) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
